@@ hdl/lrsa_pkg.sv @@
package lrsa_pkg;

	// Sizes of the register file, the spill area and a value id.
	localparam int MAX_REGS    = 16;
	localparam int SPILL_CELLS = 64;
	localparam int VALUE_BITS  = 16;

	// Classification handed from the front part to the back part.
	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
	} lrsa_req_t;

	// Result record delivered to the output register.
	typedef struct packed {
		logic [3:0]  reg_index;
		logic        store_done;
		logic [5:0]  store_cell;
		logic [15:0] store_value;
		logic        load_done;
		logic [5:0]  load_cell;
		logic        out_of_cells;
	} lrsa_res_t;

endpackage

@@ hdl/lrsa_fifo.sv @@
module lrsa_fifo import lrsa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  lrsa_req_t in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output lrsa_req_t out_data
);
	// Two-entry queue between the request front and the allocation engine.
	lrsa_req_t  mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) mem_q[wp_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (out_valid && out_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, in_valid && in_ready} - {1'b0, out_valid && out_ready};
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count overflow");
endmodule

@@ hdl/lrsa_engine.sv @@
module lrsa_engine import lrsa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [4:0] reg_limit,
	input  logic       req_valid,
	output logic       req_ready,
	input  lrsa_req_t  req,
	output logic       res_valid,
	input  logic       res_ready,
	output lrsa_res_t  res
);
	localparam int RW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
	localparam int CW = (SPILL_CELLS > 1) ? $clog2(SPILL_CELLS) : 1;
	localparam int AW = $clog2(MAX_REGS + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_REGS = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_DONE = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0] state_q;

	logic [MAX_REGS-1:0]   busy_q, mapped_q;
	logic [VALUE_BITS-1:0] holds_q [MAX_REGS];
	logic [RW-1:0]         age_q   [MAX_REGS];
	logic [AW-1:0]         age_cnt_q;
	logic [SPILL_CELLS-1:0] taken_q;

	logic [VALUE_BITS-1:0] v_q;
	logic                  hit_q, free_q;
	logic [RW-1:0]         r_q;
	logic [CW:0]           scan_q;
	logic                  load_found_q, sc_found_q;
	logic [CW-1:0]         load_q, sc_q;
	lrsa_res_t             res_q;

	// scan: the registered read data of the previous address is compared
	logic [CW-1:0] prev_q;
	logic          prev_v_q;

	logic [RW-1:0] victim;
	logic          evict, do_store, no_cell;
	logic [RW-1:0] rfin;

	// spill cell store; written at the eviction, read one cell per scan step
	logic [VALUE_BITS-1:0] cell_rd;
	logic                  cell_we;
	logic [CW-1:0]         cell_wa;
	logic [CW-1:0]         scan_idx;

	assign scan_idx = scan_q[CW-1:0];
	assign victim   = (age_cnt_q != '0) ? age_q[0] : '0;

	lrsa_ram #(.WIDTH(VALUE_BITS), .DEPTH(SPILL_CELLS)) u_cells (
		.clk(clk), .we(cell_we), .waddr(cell_wa), .wdata(holds_q[victim]),
		.raddr(scan_idx), .rdata(cell_rd)
	);

	// usable register count
	logic [AW-1:0] n_use;
	always_comb begin
		if (reg_limit == 5'd0) n_use = AW'(1);
		else if (32'(reg_limit) > MAX_REGS) n_use = AW'(MAX_REGS);
		else n_use = AW'(reg_limit);
	end

	// register lookup and lowest free register
	logic          hit_c, free_c;
	logic [RW-1:0] hit_r, free_r;
	always_comb begin
		hit_c = 1'b0; hit_r = '0; free_c = 1'b0; free_r = '0;
		for (int i = MAX_REGS - 1; i >= 0; i--) begin
			if (mapped_q[i] && holds_q[i] == v_q) begin
				hit_c = 1'b1; hit_r = RW'(i);
			end
			if (!busy_q[i] && i < 32'(n_use)) begin
				free_c = 1'b1; free_r = RW'(i);
			end
		end
	end

	assign evict    = !hit_q && !free_q;
	assign do_store = evict && mapped_q[victim];
	assign no_cell  = do_store && !sc_found_q;
	assign cell_we  = (state_q == ST_DONE) && do_store && sc_found_q;
	assign cell_wa  = sc_q;

	assign req_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_OUT);
	assign res       = res_q;

	assign rfin = hit_q ? r_q : (free_q ? r_q : victim);

	// The age list holds each register once, so the refresh removes at most one entry
	// and closes the gap before appending the register at the young end.
	logic          age_hit;
	logic [RW-1:0] age_pos;
	logic [AW-1:0] age_tail, age_cnt_nx;
	logic [RW-1:0] age_nx [MAX_REGS];
	always_comb begin
		age_hit = 1'b0;
		age_pos = '0;
		for (int i = MAX_REGS - 1; i >= 0; i--) begin
			if (AW'(i) < age_cnt_q && age_q[i] == rfin) begin
				age_hit = 1'b1;
				age_pos = RW'(i);
			end
		end
		age_tail   = age_hit ? age_cnt_q - 1'b1 : age_cnt_q;
		age_cnt_nx = (32'(age_tail) < MAX_REGS) ? age_tail + 1'b1 : age_tail;
		for (int i = 0; i < MAX_REGS - 1; i++)
			age_nx[i] = (age_hit && RW'(i) >= age_pos) ? age_q[i + 1] : age_q[i];
		age_nx[MAX_REGS - 1] = age_q[MAX_REGS - 1];
		for (int i = 0; i < MAX_REGS; i++)
			if (AW'(i) == age_tail) age_nx[i] = rfin;
	end

	// spill cell bookkeeping and the result record
	logic [SPILL_CELLS-1:0] taken_nx;
	lrsa_res_t              res_nx;
	always_comb begin
		taken_nx = taken_q;
		res_nx   = '0;
		if (no_cell) begin
			res_nx.out_of_cells = 1'b1;
		end else begin
			res_nx.reg_index = 4'(rfin);
			if (do_store) begin
				taken_nx[sc_q]     = 1'b1;
				res_nx.store_done  = 1'b1;
				res_nx.store_cell  = 6'(sc_q);
				res_nx.store_value = 16'(holds_q[victim]);
			end
			if (!hit_q && load_found_q) begin
				taken_nx[load_q] = 1'b0;
				res_nx.load_done = 1'b1;
				res_nx.load_cell = 6'(load_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) v_q <= req.value;
		if (state_q == ST_DONE && !no_cell) holds_q[rfin] <= v_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q <= '0; mapped_q <= '0; taken_q <= '0; age_cnt_q <= '0;
			hit_q <= 1'b0; free_q <= 1'b0; r_q <= '0; scan_q <= '0;
			load_found_q <= 1'b0; sc_found_q <= 1'b0; load_q <= '0; sc_q <= '0;
			prev_q <= '0; prev_v_q <= 1'b0; res_q <= '0;
			for (int i = 0; i < MAX_REGS; i++) age_q[i] <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (req_valid) state_q <= ST_REGS;
				ST_REGS: begin
					hit_q  <= hit_c;
					free_q <= free_c;
					r_q    <= hit_c ? hit_r : free_r;
					load_found_q <= 1'b0; sc_found_q <= 1'b0;
					scan_q <= '0; prev_v_q <= 1'b0;
					state_q <= hit_c ? ST_DONE : ST_SCAN;
				end
				ST_SCAN: begin
					// check the cell read on the previous step
					if (prev_v_q && taken_q[prev_q] && cell_rd == v_q && !load_found_q) begin
						load_found_q <= 1'b1; load_q <= prev_q;
					end
					if (scan_q < (CW+1)'(SPILL_CELLS)) begin
						if (!taken_q[scan_idx] && !sc_found_q) begin
							sc_found_q <= 1'b1; sc_q <= scan_idx;
						end
						prev_q <= scan_idx; prev_v_q <= 1'b1;
						scan_q <= scan_q + 1'b1;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					res_q <= res_nx;
					if (!no_cell) begin
						for (int i = 0; i < MAX_REGS; i++) age_q[i] <= age_nx[i];
						age_cnt_q <= age_cnt_nx;
						busy_q[rfin] <= 1'b1;
						mapped_q[rfin] <= 1'b1;
						taken_q <= taken_nx;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: if (res_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && res_valid)) else $error("accept while result pending");
	a_age: assert property (@(posedge clk) disable iff (!arst_n)
		32'(age_cnt_q) <= MAX_REGS) else $error("age list overflow");
	a_oob: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.out_of_cells |-> res.reg_index == 4'd0 && !res.store_done)
		else $error("out of cells result not clean");
endmodule

@@ hdl/lrsa_ram.sv @@
module lrsa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

@@ hdl/lru_register_spill_allocator_top.sv @@
// The engine handles one request at a time, and a result waits until the result side takes it;
// the front queue can hold further requests meanwhile.
// A hit goes from the lookup straight to the update; a miss first reads every spill cell
// through the single read port.
// Reset (arst_n, asynchronous, low) empties all registers, the age list and all cells,
// and sets the register count to 16; no clearing pass is needed.
module lru_register_spill_allocator_top import lrsa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [4:0]            cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [VALUE_BITS-1:0] req_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [3:0]            reg_index,
	output logic                  store_done,
	output logic [5:0]            store_cell,
	output logic [15:0]           store_value,
	output logic                  load_done,
	output logic [5:0]            load_cell,
	output logic                  out_of_cells
);
	// The configuration register holds the usable register count.
	logic [4:0] reg_limit_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) reg_limit_q <= 5'd16;
		else if (cfg_we) reg_limit_q <= cfg_wdata;
	end

	// The front queue takes requests while the engine works on an earlier one.
	lrsa_req_t in_req, q_req;
	logic      q_valid, q_ready;
	lrsa_res_t res;

	assign in_req.value = req_value;

	lrsa_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_req),
		.out_valid(q_valid), .out_ready(q_ready), .out_data(q_req)
	);

	// The engine performs lookup, spill and age update for one request at a time.
	lrsa_engine u_engine (
		.clk(clk), .arst_n(arst_n), .reg_limit(reg_limit_q),
		.req_valid(q_valid), .req_ready(q_ready), .req(q_req),
		.res_valid(out_valid), .res_ready(out_ready), .res(res)
	);

	assign reg_index    = res.reg_index;
	assign store_done   = res.store_done;
	assign store_cell   = res.store_cell;
	assign store_value  = res.store_value;
	assign load_done    = res.load_done;
	assign load_cell    = res.load_cell;
	assign out_of_cells = res.out_of_cells;
endmodule

@@ tb/tb_lru_register_spill_allocator_top.sv @@
module tb_lru_register_spill_allocator_top import lrsa_pkg::*; ;

	localparam int NREGS      = MAX_REGS;
	localparam int NCELLS     = SPILL_CELLS;
	// The longest correct pause between two acceptances is one full cell scan plus the
	// longest gap on either side; the settling pause before a register write is longer.
	localparam int SETTLE     = 100;
	localparam int STALL_LIMIT = 2000;
	localparam int EXP_DEPTH  = 512;
	localparam int POOL_SIZE  = 64;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [4:0]  cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] req_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  reg_index;
	logic        store_done;
	logic [5:0]  store_cell;
	logic [15:0] store_value;
	logic        load_done;
	logic [5:0]  load_cell;
	logic        out_of_cells;

	// Mirror of the allocator: register file, age list and spill cells.
	bit          reg_busy_m [NREGS];
	bit          reg_mapped_m [NREGS];
	logic [15:0] reg_holds_m [NREGS];
	int          age_list [NREGS];
	int          age_len;
	bit          cell_taken_m [NCELLS];
	logic [15:0] cell_holds_m [NCELLS];
	logic [4:0]  reg_limit_m;

	// Expected results in request order.
	lrsa_res_t   exp_mem [EXP_DEPTH];
	int          exp_wr = 0;
	int          exp_rd = 0;
	logic [15:0] value_pool [POOL_SIZE];
	int          pool_len = 0;
	int          errors = 0;
	int          idle_cycles = 0;
	bit          quiet = 1'b0;
	int          ready_hold = 0;

	always #5 clk = ~clk;

	lru_register_spill_allocator_top u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .req_value(req_value),
		.out_valid(out_valid), .out_ready(out_ready), .reg_index(reg_index),
		.store_done(store_done), .store_cell(store_cell), .store_value(store_value),
		.load_done(load_done), .load_cell(load_cell), .out_of_cells(out_of_cells)
	);

	// Move a register to the most recently used end of the age list.
	function automatic void refresh_age(int r);
		int j;
		j = 0;
		for (int i = 0; i < age_len; i++) begin
			if (age_list[i] != r) begin
				age_list[j] = age_list[i];
				j++;
			end
		end
		age_len = j;
		if (age_len < NREGS) begin
			age_list[age_len] = r;
			age_len++;
		end
	endfunction

	// Works out the allocation for one request and updates the mirror state.
	function automatic lrsa_res_t allocate_register(logic [15:0] v);
		lrsa_res_t res;
		int n, r, reload, victim, spare;
		bit hit, have_free;
		res = '0;
		r = 0;
		hit = 1'b0;
		reload = -1;
		n = (reg_limit_m == 0) ? 1 : (reg_limit_m > NREGS) ? NREGS : int'(reg_limit_m);
		for (int i = 0; i < NREGS && !hit; i++) begin
			if (reg_mapped_m[i] && reg_holds_m[i] == v) begin
				r = i;
				hit = 1'b1;
			end
		end
		if (!hit) begin
			have_free = 1'b0;
			for (int i = 0; i < NCELLS && reload < 0; i++)
				if (cell_taken_m[i] && cell_holds_m[i] == v) reload = i;
			for (int i = 0; i < n && !have_free; i++) begin
				if (!reg_busy_m[i]) begin
					r = i;
					have_free = 1'b1;
				end
			end
			if (!have_free) begin
				victim = (age_len > 0) ? age_list[0] : 0;
				if (reg_mapped_m[victim]) begin
					// The cell about to be reloaded is still taken here, so it is never reused.
					spare = -1;
					for (int i = 0; i < NCELLS && spare < 0; i++)
						if (!cell_taken_m[i]) spare = i;
					if (spare < 0) begin
						res.out_of_cells = 1'b1;
						return res;
					end
					cell_taken_m[spare] = 1'b1;
					cell_holds_m[spare] = reg_holds_m[victim];
					reg_mapped_m[victim] = 1'b0;
					res.store_done = 1'b1;
					res.store_cell = spare[5:0];
					res.store_value = reg_holds_m[victim];
				end
				r = victim;
			end
			if (reload >= 0) begin
				cell_taken_m[reload] = 1'b0;
				res.load_done = 1'b1;
				res.load_cell = reload[5:0];
			end
		end
		refresh_age(r);
		reg_busy_m[r] = 1'b1;
		reg_mapped_m[r] = 1'b1;
		reg_holds_m[r] = v;
		res.reg_index = r[3:0];
		return res;
	endfunction

	// Issues one request and returns at the edge where it is accepted, leaving valid high
	// so that a following request can be presented without a bubble.
	task automatic send_request(logic [15:0] v);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_value <= v;
		exp_mem[exp_wr % EXP_DEPTH] = allocate_register(v);
		exp_wr++;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	// The register is only written once every allocation has come back and the block
	// has had time to finish any scan still under way.
	task automatic write_reg_limit(logic [4:0] v);
		in_valid <= 1'b0;
		wait (exp_wr == exp_rd);
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_limit_m = v;
	endtask

	// With a single register every new value evicts the last one, so the spill cells
	// fill up and the next eviction must report that none is left.
	task automatic test_spill_exhaustion();
		write_reg_limit(5'd1);
		for (int k = 0; k < NCELLS + 3; k++) send_request(16'h0100 + k[15:0]);
		send_request(16'h0100);
	endtask

	// Full register file: extreme values, a hit, evictions of the oldest register and a request
	// for a value pushed out earlier; the spill cells are still full, so each eviction reports that none is left.
	task automatic test_evict_and_reload();
		write_reg_limit(5'd16);
		send_request(16'h0000);
		send_request(16'hFFFF);
		send_request(16'h0000);
		for (int k = 0; k < 15; k++) send_request(16'h1 << k);
		send_request(16'h1234);
		send_request(16'hFFFF);
		send_request(16'h0101);
	endtask

	// Register counts out of range and below the registers already in use.
	task automatic test_count_extremes();
		write_reg_limit(5'd0);
		send_request(16'hA5A5);
		send_request(16'h0102);
		write_reg_limit(5'd31);
		send_request(16'h5A5A);
		send_request(16'h0103);
		write_reg_limit(5'd4);
		send_request(16'h0004);
		send_request(16'h1234);
	endtask

	// Mostly values from a shared pool so that hits, spills and reloads recur; the rest
	// are arbitrary values that push the spill area towards its limit.
	task automatic test_random_traffic();
		logic [4:0] counts [4];
		counts = '{5'd7, 5'd31, 5'd2, 5'd16};
		for (int k = 0; k < 40; k++) begin
			value_pool[pool_len] = 16'h0100 + k[15:0];
			pool_len++;
		end
		for (int k = 0; k < 24; k++) begin
			value_pool[pool_len] = 16'($urandom);
			pool_len++;
		end
		for (int phase = 0; phase < 4; phase++) begin
			write_reg_limit(phase == 0 ? 5'($urandom_range(1, 16)) : counts[phase]);
			if (phase == 3) quiet = 1'b1;
			for (int k = 0; k < 75; k++) begin
				if ($urandom_range(0, 9) < 7)
					send_request(value_pool[$urandom_range(0, pool_len - 1)]);
				else
					send_request(16'($urandom));
			end
		end
	endtask

	task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// The receiving side stalls in bursts until the quiet part of the run.
	always @(posedge clk) begin
		if (quiet) begin
			out_ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			ready_hold <= $urandom_range(1, 15);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Sampled at the falling edge, where both handshake sides are settled; a result seen
	// with valid and ready high here is taken at the next rising edge.
	always @(negedge clk) begin
		lrsa_res_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (exp_wr == exp_rd) begin
				$display("%0t: result mismatch, expected none, actual reg_index %0h", $time,
					reg_index);
				errors++;
			end else begin
				exp_r = exp_mem[exp_rd % EXP_DEPTH];
				exp_rd++;
				check_field("reg_index", 16'(exp_r.reg_index), 16'(reg_index));
				check_field("store_done", 16'(exp_r.store_done), 16'(store_done));
				check_field("store_cell", 16'(exp_r.store_cell), 16'(store_cell));
				check_field("store_value", exp_r.store_value, store_value);
				check_field("load_done", 16'(exp_r.load_done), 16'(load_done));
				check_field("load_cell", 16'(exp_r.load_cell), 16'(load_cell));
				check_field("out_of_cells", 16'(exp_r.out_of_cells), 16'(out_of_cells));
			end
		end
	end

	// Watchdog on cycles in which neither side moves a request or a result.
	always @(negedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		reg_limit_m = 5'd16;
		age_len = 0;
		foreach (reg_busy_m[i]) begin
			reg_busy_m[i] = 1'b0;
			reg_mapped_m[i] = 1'b0;
			reg_holds_m[i] = '0;
			age_list[i] = 0;
		end
		foreach (cell_taken_m[i]) begin
			cell_taken_m[i] = 1'b0;
			cell_holds_m[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_spill_exhaustion();
		test_evict_and_reload();
		test_count_extremes();
		test_random_traffic();
		in_valid <= 1'b0;
		wait (exp_wr == exp_rd);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

@@ lru_register_spill_allocator_top.f @@
hdl/lrsa_pkg.sv
hdl/lrsa_fifo.sv
hdl/lrsa_engine.sv
hdl/lrsa_ram.sv
hdl/lru_register_spill_allocator_top.sv
tb/tb_lru_register_spill_allocator_top.sv
